/* rtl/ffea_pkg.sv */
package ffea_pkg;

   localparam int FREE_W = 36;
   localparam logic [FREE_W-1:0] FREE_MAX = 36'hF_FFFF_FFFF;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_ALLOC = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SMALL = 2'd1,
      ST_NOFIT = 2'd2,
      ST_FULL  = 2'd3
   } stat_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CMP,
      FSM_APPLY
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic compare;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_blocked;
   } dp_status_type;

endpackage

/* rtl/first_fit_extent_allocator_top.sv */
// First-fit extent allocator.
// Request channel (req_valid / req_stall): req_opcode 0 appends a free extent
// (req_extent_start, req_byte_count) at the tail of a table of SLOTS entries;
// req_opcode 1 asks for req_byte_count bytes plus the header size.
// Response channel (rsp_valid / rsp_stall): exactly one result per request,
// with granted address and length, a status code and the free byte total.
// A transfer happens on a clock edge with valid high and stall low.
// Config channel (csr_valid / csr_ready / csr_data): sets the header size;
// csr_ready is always high, write only while the block is idle.
// Steps: load the request, compare all slots in parallel, then apply and
// register the result; the request side is stalled meanwhile, so the block
// takes no new request until the result of the last one is registered.
// The apply step is where the first match is picked and the table trimmed
// or shifted up in one go.
// If rsp_stall holds a previous result, the apply step waits and the
// request side keeps stalling until the result register frees.
// Reset (synchronous, active high) empties the table, zeroes the free total
// and sets the header size to 16.
module first_fit_extent_allocator_top import ffea_pkg::*; #(
   parameter int SLOTS      = 16,
   parameter int ADDR_BITS  = 32,
   parameter int WORD_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [31:0]       req_extent_start,
   input  logic [31:0]       req_byte_count,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_granted_address,
   output logic [31:0]       rsp_granted_length,
   output logic [1:0]        rsp_status,
   output logic [FREE_W-1:0] rsp_free_bytes
);

   cmd_type       cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   ffea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   ffea_dp #(
      .SLOTS      (SLOTS),
      .ADDR_BITS  (ADDR_BITS),
      .WORD_BYTES (WORD_BYTES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .dp_status           (dp_status),
      .csr_valid           (csr_valid),
      .csr_data            (csr_data),
      .req_opcode          (req_opcode),
      .req_extent_start    (req_extent_start),
      .req_byte_count      (req_byte_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_address (rsp_granted_address),
      .rsp_granted_length  (rsp_granted_length),
      .rsp_status          (rsp_status),
      .rsp_free_bytes      (rsp_free_bytes)
   );

endmodule

/* rtl/ffea_ctrl.sv */
module ffea_ctrl import ffea_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.compare = 1'b0;
      cmd.commit  = 1'b0;
      req_stall   = (state_ff != FSM_IDLE);
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = FSM_CMP;
            end
         end
         FSM_CMP: begin
            cmd.compare = 1'b1;
            state_in    = FSM_APPLY;
         end
         FSM_APPLY: begin
            // wait for the result register to free up
            if (!dp_status.rsp_blocked) begin
               cmd.commit = 1'b1;
               state_in   = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   a_cmp_then_apply: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_CMP |=> state_ff == FSM_APPLY)
      else $error("compare step not followed by apply");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.load, cmd.compare, cmd.commit}) <= 1)
      else $error("more than one datapath command at once");

   a_load_on_transfer: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> req_valid && !req_stall)
      else $error("item loaded without a request transfer");

endmodule

/* rtl/ffea_dp.sv */
module ffea_dp import ffea_pkg::*; #(
   parameter int SLOTS      = 16,
   parameter int ADDR_BITS  = 32,
   parameter int WORD_BYTES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output dp_status_type       dp_status,
   input  logic                csr_valid,
   input  logic [7:0]          csr_data,
   input  logic                req_opcode,
   input  logic [31:0]         req_extent_start,
   input  logic [31:0]         req_byte_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_granted_address,
   output logic [31:0]         rsp_granted_length,
   output logic [1:0]          rsp_status,
   output logic [FREE_W-1:0]   rsp_free_bytes
);

   localparam int CW   = $clog2(SLOTS + 1);
   localparam int SUMW = ADDR_BITS + 33;

   // table
   logic [ADDR_BITS-1:0] slot_start_ff [SLOTS];
   logic [31:0]          slot_len_ff   [SLOTS];
   logic [ADDR_BITS-1:0] slot_start_in [SLOTS];
   logic [31:0]          slot_len_in   [SLOTS];
   logic [ADDR_BITS-1:0] shift_start   [SLOTS];
   logic [31:0]          shift_len     [SLOTS];
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [FREE_W-1:0]    free_ff, free_in;
   logic [7:0]           hdr_ff;

   // item being worked on
   logic        op_ff;
   logic [31:0] start_ff;
   logic [31:0] count_ff;
   logic [32:0] total_ff;
   logic [SLOTS-1:0] fit_ff, fit_in;

   // result register
   logic              rsp_valid_ff;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;
   logic [31:0]       rsp_len_ff, rsp_len_in;
   stat_type          rsp_stat_ff, rsp_stat_in;
   logic [FREE_W-1:0] rsp_free_ff;

   // apply-step terms
   logic [SLOTS-1:0]     first, ge;
   logic                 hit, trim, short_req, full;
   logic [ADDR_BITS-1:0] sel_start;
   logic [31:0]          sel_len;
   logic [32:0]          rem;
   logic [31:0]          glen;
   logic [FREE_W:0]      free_sum;

   assign dp_status.rsp_blocked = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= 8'd16;
      end else if (csr_valid) begin
         hdr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         start_ff <= req_extent_start;
         count_ff <= req_byte_count;
         total_ff <= 33'(req_byte_count) + 33'(hdr_ff);
      end
      if (cmd.compare) begin
         fit_ff <= fit_in;
      end
   end

   // one comparator per slot; only the valid prefix may match
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         fit_in[i] = (CW'(i) < cnt_ff) && ({1'b0, slot_len_ff[i]} >= total_ff);
      end
   end

   always_comb begin
      first     = fit_ff & (~fit_ff + SLOTS'(1));
      ge        = ~(first - SLOTS'(1));
      hit       = |fit_ff;
      sel_start = '0;
      sel_len   = '0;
      for (int i = 0; i < SLOTS; i++) begin
         sel_start = sel_start | (first[i] ? slot_start_ff[i] : '0);
         sel_len   = sel_len | (first[i] ? slot_len_ff[i] : '0);
      end
      rem       = {1'b0, sel_len} - total_ff;
      trim      = rem >= 33'(WORD_BYTES);
      glen      = trim ? total_ff[31:0] : sel_len;
      short_req = count_ff < 32'(WORD_BYTES);
      full      = cnt_ff == CW'(SLOTS);
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_shift
      if (g < SLOTS - 1) begin : g_mid
         assign shift_start[g] = slot_start_ff[g+1];
         assign shift_len[g]   = slot_len_ff[g+1];
      end else begin : g_last
         assign shift_start[g] = slot_start_ff[g];
         assign shift_len[g]   = slot_len_ff[g];
      end
   end

   always_comb begin
      cnt_in      = cnt_ff;
      free_in     = free_ff;
      rsp_addr_in = '0;
      rsp_len_in  = '0;
      rsp_stat_in = ST_OK;
      free_sum    = {1'b0, free_ff} + (FREE_W + 1)'(count_ff);
      for (int i = 0; i < SLOTS; i++) begin
         slot_start_in[i] = slot_start_ff[i];
         slot_len_in[i]   = slot_len_ff[i];
      end
      if (op_ff == OP_ADD) begin
         if (full) begin
            rsp_stat_in = ST_FULL;
         end else begin
            for (int i = 0; i < SLOTS; i++) begin
               if (CW'(i) == cnt_ff) begin
                  slot_start_in[i] = ADDR_BITS'(start_ff);
                  slot_len_in[i]   = count_ff;
               end
            end
            cnt_in  = cnt_ff + CW'(1);
            free_in = (free_sum >= {1'b0, FREE_MAX}) ? FREE_MAX : free_sum[FREE_W-1:0];
         end
      end else if (short_req) begin
         rsp_stat_in = ST_SMALL;
      end else if (!hit) begin
         rsp_stat_in = ST_NOFIT;
      end else begin
         rsp_addr_in = 32'(sel_start);
         rsp_len_in  = glen;
         if (trim) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (first[i]) begin
                  slot_start_in[i] = ADDR_BITS'(SUMW'(sel_start) + SUMW'(total_ff));
                  slot_len_in[i]   = rem[31:0];
               end
            end
         end else begin
            // whole extent taken: close the gap
            for (int i = 0; i < SLOTS; i++) begin
               if (ge[i]) begin
                  slot_start_in[i] = shift_start[i];
                  slot_len_in[i]   = shift_len[i];
               end
            end
            cnt_in = cnt_ff - CW'(1);
         end
         free_in = (FREE_W'(glen) >= free_ff) ? '0 : free_ff - FREE_W'(glen);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_start_ff[i] <= slot_start_in[i];
            slot_len_ff[i]   <= slot_len_in[i];
         end
         rsp_addr_ff <= rsp_addr_in;
         rsp_len_ff  <= rsp_len_in;
         rsp_stat_ff <= rsp_stat_in;
         rsp_free_ff <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            cnt_ff  <= cnt_in;
            free_ff <= free_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_granted_length  = rsp_len_ff;
   assign rsp_status          = rsp_stat_ff;
   assign rsp_free_bytes      = rsp_free_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(SLOTS))
      else $error("slot count beyond table size");

   a_remove_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && op_ff == OP_ALLOC && !short_req && hit && !trim
      |=> cnt_ff == $past(cnt_ff) - CW'(1))
      else $error("whole-extent grant did not drop slot count");

   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && rsp_free_ff == free_ff)
      else $error("result not loaded on commit");

endmodule

/* bench/first_fit_extent_allocator_top_tb.sv */
module first_fit_extent_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ffea_pkg::*;

   localparam int SLOT_COUNT  = 16;
   localparam int WORD_SIZE   = 8;
   localparam int SETTLE      = 6;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      logic [31:0]       addr;
      logic [31:0]       len;
      stat_type          status;
      logic [FREE_W-1:0] free;
   } grant_type;

   typedef enum {PACE_OPEN, PACE_LIGHT, PACE_HEAVY, PACE_TOGGLE} pace_type;

   class alloc_scoreboard;
      logic [31:0]       ext_start [SLOT_COUNT];
      logic [31:0]       ext_len   [SLOT_COUNT];
      int unsigned       fill         = 0;
      logic [FREE_W-1:0] free_total   = '0;
      logic [7:0]        header_bytes = 8'd16;
      grant_type         grant_queue[$];
      int unsigned       failures     = 0;

      // Works out the grant for one accepted request and queues it.
      function void note_request(op_type op, logic [31:0] start, logic [31:0] count);
         grant_type   g;
         logic [32:0] need;
         logic [32:0] rest;
         int          hit;
         int          i;
         g.addr   = '0;
         g.len    = '0;
         g.status = ST_OK;
         if (op == OP_ADD) begin
            if (fill == SLOT_COUNT) begin
               g.status = ST_FULL;
            end else begin
               ext_start[fill] = start;
               ext_len[fill]   = count;
               fill++;
               if ({4'b0, count} >= FREE_MAX - free_total)
                  free_total = FREE_MAX;
               else
                  free_total = free_total + count;
            end
         end else if (count < WORD_SIZE) begin
            g.status = ST_SMALL;
         end else begin
            // header added at full width, so a huge request can never wrap into a fit
            need = {1'b0, count} + header_bytes;
            hit  = -1;
            for (i = 0; i < fill && hit < 0; i++)
               if ({1'b0, ext_len[i]} >= need)
                  hit = i;
            if (hit < 0) begin
               g.status = ST_NOFIT;
            end else begin
               g.addr = ext_start[hit];
               rest   = {1'b0, ext_len[hit]} - need;
               if (rest >= WORD_SIZE) begin
                  ext_start[hit] = ext_start[hit] + need[31:0];
                  ext_len[hit]   = rest[31:0];
                  g.len          = need[31:0];
               end else begin
                  // remainder under a word: whole extent goes, later ones move up
                  g.len = ext_len[hit];
                  for (i = hit; i + 1 < fill; i++) begin
                     ext_start[i] = ext_start[i + 1];
                     ext_len[i]   = ext_len[i + 1];
                  end
                  fill--;
               end
               if (g.len >= free_total)
                  free_total = '0;
               else
                  free_total = free_total - g.len;
            end
         end
         g.free = free_total;
         grant_queue.push_back(g);
      endfunction

      function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
         if (exp !== act) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            failures++;
         end
      endfunction

      function void check_grant(logic [31:0] addr, logic [31:0] len, logic [1:0] status,
                                logic [FREE_W-1:0] free);
         grant_type g;
         if (grant_queue.size() == 0) begin
            $error("response transfer with no request outstanding");
            failures++;
         end else begin
            g = grant_queue.pop_front();
            compare_field("granted_address", g.addr, addr);
            compare_field("granted_length", g.len, len);
            compare_field("status", g.status, status);
            compare_field("free_bytes", g.free, free);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [7:0]        csr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_opcode = 1'b0;
   logic [31:0]       req_extent_start = '0;
   logic [31:0]       req_byte_count = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [31:0]       rsp_granted_address;
   logic [31:0]       rsp_granted_length;
   logic [1:0]        rsp_status;
   logic [FREE_W-1:0] rsp_free_bytes;

   int unsigned       hold_requests = 0;
   int unsigned       cycles = 0;

   alloc_scoreboard   sb = new;

   first_fit_extent_allocator_top #(
      .SLOTS      (SLOT_COUNT),
      .ADDR_BITS  (32),
      .WORD_BYTES (WORD_SIZE)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_extent_start    (req_extent_start),
      .req_byte_count      (req_byte_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_address (rsp_granted_address),
      .rsp_granted_length  (rsp_granted_length),
      .rsp_status          (rsp_status),
      .rsp_free_bytes      (rsp_free_bytes)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_grant(rsp_granted_address, rsp_granted_length, rsp_status, rsp_free_bytes);
   end

   // receiver back-pressure: random modes, plus a long hold when asked for
   initial begin : rsp_pacing
      pace_type    mode;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned holds_seen;
      mode       = PACE_OPEN;
      mode_left  = 0;
      hold_left  = 0;
      holds_seen = 0;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = pace_type'($urandom_range(0, 3));
            mode_left = $urandom_range(1, 64);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               PACE_OPEN:  rsp_stall <= 1'b0;
               PACE_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               PACE_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
               default:    rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   task automatic send_item(op_type op, logic [31:0] start, logic [31:0] count);
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_extent_start <= start;
      req_byte_count   <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, start, count);
   endtask

   task automatic pause_sender(int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.grant_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_header(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.header_bytes = value;
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(int unsigned add_pct);
      op_type      op;
      logic [31:0] start;
      logic [31:0] count;
      logic [32:0] cut;
      int unsigned pct;
      int unsigned pick;
      int unsigned k;
      pct  = (sb.fill < 3 && add_pct < 70) ? 70 : add_pct;
      op   = ($urandom_range(0, 99) < pct) ? OP_ADD : OP_ALLOC;
      pick = $urandom_range(0, 99);
      // near the top of the address space so trims wrap round
      start = (pick < 10) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom();
      pick = $urandom_range(0, 99);
      if (op == OP_ADD) begin
         if (pick < 8)
            count = '0;
         else if (pick < 15)
            count = $urandom();
         else if (pick < 20)
            count = 32'hFFFF_FFFF - $urandom_range(0, 64);
         else
            count = $urandom_range(1, 8192);
      end else begin
         if (pick < 6) begin
            count = $urandom_range(0, WORD_SIZE - 1);
         end else if (pick < 12) begin
            count = $urandom();
         end else if (pick < 55 && sb.fill != 0) begin
            // aim just around an extent's size: exact fit, short remainder, trim
            k   = $urandom_range(0, sb.fill - 1);
            cut = 33'($urandom_range(0, 12)) + 33'(sb.header_bytes);
            if ({1'b0, sb.ext_len[k]} >= cut)
               count = sb.ext_len[k] - cut[31:0];
            else
               count = $urandom_range(WORD_SIZE, 64);
         end else begin
            count = $urandom_range(WORD_SIZE, 4096);
         end
      end
      send_item(op, start, count);
   endtask

   task automatic run_random(int unsigned n, int unsigned add_pct, bit long_hold);
      int unsigned sent;
      int unsigned burst;
      sent = 0;
      while (sent < n) begin
         burst = $urandom_range(1, 24);
         while (burst != 0 && sent < n) begin
            if (sent == n / 2) begin
               if (long_hold)
                  hold_requests <= hold_requests + 1;
               else
                  wait_drained();
            end
            send_random(add_pct);
            sent++;
            burst--;
         end
         if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 12));
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // header at its reset value of 16 here
      send_item(OP_ALLOC, 32'h0, 32'd8);
      send_item(OP_ALLOC, 32'h0, 32'd0);
      send_item(OP_ALLOC, 32'h0, 32'd7);
      send_item(OP_ADD, 32'h0000_1000, 32'd0);
      send_item(OP_ADD, 32'h0000_2000, 32'd40);
      send_item(OP_ADD, 32'hFFFF_FFF0, 32'h100);
      send_item(OP_ALLOC, 32'h0, 32'd24);
      send_item(OP_ALLOC, 32'h0, 32'd8);
      send_item(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);
      send_item(OP_ALLOC, 32'h0, 32'd209);
      send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_ADD, 32'h0, 32'hFFFF_FFF0);
      send_item(OP_ALLOC, 32'h0, 32'hFFFF_FFEF);
      send_item(OP_ALLOC, 32'hDEAD_BEEF, 32'd100);

      run_random(240, 50, 1'b1);
      wait_drained();
      write_header(8'd0);
      run_random(240, 40, 1'b0);
      wait_drained();
      write_header(8'd255);
      run_random(240, 85, 1'b1);
      wait_drained();
      write_header(8'($urandom_range(1, 254)));
      run_random(240, 30, 1'b0);
      wait_drained();
      write_header(8'd8);
      run_random(240, 55, 1'b1);
      wait_drained();
      write_header(8'($urandom_range(0, 255)));
      run_random(240, 60, 1'b0);

      wait_drained();
      if (sb.failures == 0 && sb.grant_queue.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
